// File: hdl/sdiv_pkg.sv
// Shared types, widths and microcode program of the signed divider.
`timescale 1ns / 1ps
package sdiv_pkg;

    localparam int WIDTH    = 16;
    localparam int REM_W    = WIDTH + 2;
    localparam int CNT_W    = $clog2(WIDTH + 1);
    localparam int S_DATA_W = ((2 * WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * WIDTH + 7) / 8) * 8;
    localparam int UPC_W    = 2;

    typedef logic [WIDTH-1:0] data_t;
    typedef logic [REM_W-1:0] rem_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        DP_LOAD = 2'd0,
        DP_STEP = 2'd1,
        DP_FIX  = 2'd2,
        DP_EMIT = 2'd3
    } dp_op_t;

    typedef enum logic [1:0] {
        WAIT_NONE = 2'd0,
        WAIT_IN   = 2'd1,
        WAIT_OUT  = 2'd2
    } wait_t;

    typedef enum logic [1:0] {
        JMP_NEXT   = 2'd0,
        JMP_ALWAYS = 2'd1,
        JMP_CNT_NZ = 2'd2,
        JMP_ZERO   = 2'd3
    } jump_t;

    typedef struct packed {
        dp_op_t op;
        wait_t  waitc;
        jump_t  jump;
        upc_t   target;
    } uword_t;

    typedef struct packed {
        dp_op_t op;
        logic   exec;
        logic   in_ready;
    } seq_ctrl_t;

    typedef struct packed {
        logic divisor_zero;
    } dp_status_t;

    localparam upc_t UPC_LOAD = 2'd0;
    localparam upc_t UPC_STEP = 2'd1;
    localparam upc_t UPC_FIX  = 2'd2;
    localparam upc_t UPC_EMIT = 2'd3;

    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        unique case (addr)
            UPC_LOAD: w = '{op: DP_LOAD, waitc: WAIT_IN,   jump: JMP_ZERO,   target: UPC_EMIT};
            UPC_STEP: w = '{op: DP_STEP, waitc: WAIT_NONE, jump: JMP_CNT_NZ, target: UPC_STEP};
            UPC_FIX:  w = '{op: DP_FIX,  waitc: WAIT_NONE, jump: JMP_NEXT,   target: UPC_EMIT};
            UPC_EMIT: w = '{op: DP_EMIT, waitc: WAIT_OUT,  jump: JMP_ALWAYS, target: UPC_LOAD};
            default:  w = '{op: DP_EMIT, waitc: WAIT_OUT,  jump: JMP_ALWAYS, target: UPC_LOAD};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/signed_nonrestoring_divider.sv
// Top level of the microcoded signed non-restoring divider.
//
//  channel | dir | tdata (low bit up)            | tuser
//  s_      | in  | dividend, divisor             | -
//  m_      | out | quotient, remainder, zero pad | divide_by_zero
//
//  Each transaction runs one load, one add/subtract step per quotient bit, one
//  remainder correction and one sign fix into the output register. A zero divisor
//  jumps from load straight to emit.
//  Synchronous active-low reset returns the sequencer to its load step and drops m_tvalid.
//  The result waits in the output register while the next transaction is
//  loaded and worked; only its emit step stalls on an untaken result.
`timescale 1ns / 1ps
module signed_nonrestoring_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sdiv_pkg::S_DATA_W-1:0]    s_tdata,   // dividend, divisor
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sdiv_pkg::M_DATA_W-1:0]    m_tdata,   // quotient, remainder, zero pad
    output logic                             m_tuser    // divide_by_zero
);
    import sdiv_pkg::*;

    seq_ctrl_t  ctrl;
    dp_status_t status;
    data_t      dividend, divisor, quotient, remainder;
    logic       out_free;

    assign dividend = s_tdata[WIDTH-1:0];
    assign divisor  = s_tdata[2*WIDTH-1:WIDTH];
    assign out_free = !m_tvalid || m_tready;

    sdiv_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl)
    );

    sdiv_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .dividend       (dividend),
        .divisor        (divisor),
        .out_taken      (m_tready),
        .status         (status),
        .out_valid      (m_tvalid),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (m_tuser)
    );

    assign s_tready = ctrl.in_ready;
    assign m_tdata  = M_DATA_W'({remainder, quotient});

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted during a division");

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("divide by zero result not cleared");

    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("untaken result dropped");
`endif

endmodule

// File: hdl/sdiv_sequencer.sv
// Microcode sequencer: step counter, iteration counter and jump logic.
`timescale 1ns / 1ps
module sdiv_sequencer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic                   out_free,
    input  sdiv_pkg::dp_status_t   status,
    output sdiv_pkg::seq_ctrl_t    ctrl
);
    import sdiv_pkg::*;

    upc_t   upc_reg, upc_next;
    cnt_t   cnt_reg, cnt_next;
    uword_t uw;
    logic   exec;

    assign uw = ucode_rom(upc_reg);

    always_comb begin
        unique case (uw.waitc)
            WAIT_NONE: exec = 1'b1;
            WAIT_IN:   exec = in_valid;
            WAIT_OUT:  exec = out_free;
            default:   exec = 1'b0;
        endcase
    end

    always_comb begin
        upc_next = upc_reg;
        if (exec) begin
            unique case (uw.jump)
                JMP_NEXT:   upc_next = upc_reg + 1'b1;
                JMP_ALWAYS: upc_next = uw.target;
                JMP_CNT_NZ: upc_next = (cnt_reg != cnt_t'(1)) ? uw.target : upc_reg + 1'b1;
                JMP_ZERO:   upc_next = status.divisor_zero ? uw.target : upc_reg + 1'b1;
                default:    upc_next = UPC_LOAD;
            endcase
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (exec && uw.op == DP_LOAD) begin
            cnt_next = cnt_t'(WIDTH);
        end else if (exec && uw.op == DP_STEP) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_LOAD;
            cnt_reg <= '0;
        end else begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl = '{op: uw.op, exec: exec, in_ready: (uw.waitc == WAIT_IN)};

endmodule

// File: hdl/sdiv_datapath.sv
// Divider datapath: magnitude load, add/subtract step, correction and output register.
`timescale 1ns / 1ps
module sdiv_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sdiv_pkg::seq_ctrl_t   ctrl,
    input  sdiv_pkg::data_t       dividend,
    input  sdiv_pkg::data_t       divisor,
    input  logic                  out_taken,
    output sdiv_pkg::dp_status_t  status,
    output logic                  out_valid,
    output sdiv_pkg::data_t       quotient,
    output sdiv_pkg::data_t       remainder,
    output logic                  divide_by_zero
);
    import sdiv_pkg::*;

    rem_t  rem_reg, rem_next;
    data_t quo_reg, quo_next;
    data_t dvs_reg, dvs_next;
    logic  neg_q_reg, neg_q_next;
    logic  neg_r_reg, neg_r_next;
    logic  dbz_reg, dbz_next;
    logic  valid_reg, valid_next;
    data_t q_out_reg, q_out_next;
    data_t r_out_reg, r_out_next;
    logic  z_out_reg, z_out_next;

    data_t a_mag, b_mag;
    rem_t  shifted, d_ext, sum;
    data_t r_mag;

    assign a_mag   = dividend[WIDTH-1] ? data_t'(-dividend) : dividend;
    assign b_mag   = divisor[WIDTH-1]  ? data_t'(-divisor)  : divisor;
    assign status.divisor_zero = (divisor == '0);

    assign shifted = {rem_reg[REM_W-2:0], quo_reg[WIDTH-1]};
    assign d_ext   = {2'b00, dvs_reg};
    assign sum     = rem_reg[REM_W-1] ? shifted + d_ext : shifted - d_ext;
    assign r_mag   = rem_reg[WIDTH-1:0];

    always_comb begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        dbz_next   = dbz_reg;
        q_out_next = q_out_reg;
        r_out_next = r_out_reg;
        z_out_next = z_out_reg;
        valid_next = valid_reg && !out_taken;
        if (ctrl.exec) begin
            unique case (ctrl.op)
                DP_LOAD: begin
                    rem_next = '0;
                    dvs_next = b_mag;
                    dbz_next = status.divisor_zero;
                    if (status.divisor_zero) begin
                        quo_next   = '0;
                        neg_q_next = 1'b0;
                        neg_r_next = 1'b0;
                    end else begin
                        quo_next   = a_mag;
                        neg_q_next = dividend[WIDTH-1] ^ divisor[WIDTH-1];
                        neg_r_next = dividend[WIDTH-1];
                    end
                end
                DP_STEP: begin
                    rem_next = sum;
                    quo_next = {quo_reg[WIDTH-2:0], ~sum[REM_W-1]};
                end
                DP_FIX: begin
                    if (rem_reg[REM_W-1]) begin
                        rem_next = rem_reg + d_ext;
                    end
                end
                DP_EMIT: begin
                    q_out_next = neg_q_reg ? data_t'(-quo_reg) : quo_reg;
                    r_out_next = neg_r_reg ? data_t'(-r_mag) : r_mag;
                    z_out_next = dbz_reg;
                    valid_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        dbz_reg   <= dbz_next;
        q_out_reg <= q_out_next;
        r_out_reg <= r_out_next;
        z_out_reg <= z_out_next;
    end

    assign out_valid      = valid_reg;
    assign quotient       = q_out_reg;
    assign remainder      = r_out_reg;
    assign divide_by_zero = z_out_reg;

endmodule

// File: sim/quotient_checker.sv
// Checker for the signed divider: predicts each quotient and remainder and compares results.
`timescale 1ns / 1ps
module quotient_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sdiv_pkg::S_DATA_W-1:0] s_tdata,   // dividend, divisor
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sdiv_pkg::M_DATA_W-1:0] m_tdata,   // quotient, remainder
    input  logic                          m_tuser,   // divide_by_zero
    output int unsigned                   mismatches,
    output int unsigned                   outstanding
);
    import sdiv_pkg::*;

    typedef struct packed {
        data_t quotient;
        data_t remainder;
        logic  divide_by_zero;
    } quot_rem_t;

    quot_rem_t pending_quotients[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // truncating division, remainder takes the dividend's sign
    function automatic quot_rem_t divide_truncating(data_t num, data_t den);
        quot_rem_t res;
        logic      neg_n;
        logic      neg_d;
        data_t     mag_n;
        data_t     mag_d;
        data_t     q;
        data_t     r;
        res   = '0;
        neg_n = num[WIDTH-1];
        neg_d = den[WIDTH-1];
        if (den == '0) begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        mag_n = neg_n ? data_t'(data_t'(0) - num) : num;
        mag_d = neg_d ? data_t'(data_t'(0) - den) : den;
        q = mag_n / mag_d;
        r = mag_n % mag_d;
        res.quotient  = (neg_n != neg_d) ? data_t'(data_t'(0) - q) : q;
        res.remainder = neg_n ? data_t'(data_t'(0) - r) : r;
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        quot_rem_t got;
        quot_rem_t want;
        if (!aresetn) begin
            pending_quotients.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.quotient       = m_tdata[WIDTH-1:0];
                got.remainder      = m_tdata[2*WIDTH-1:WIDTH];
                got.divide_by_zero = m_tuser;
                if (pending_quotients.size() == 0) begin
                    report("unexpected result transaction", $signed(got.quotient), 0);
                end else begin
                    want = pending_quotients.pop_front();
                    if (got.quotient !== want.quotient)
                        report("quotient", $signed(got.quotient), $signed(want.quotient));
                    if (got.remainder !== want.remainder)
                        report("remainder", $signed(got.remainder), $signed(want.remainder));
                    if (got.divide_by_zero !== want.divide_by_zero)
                        report("divide_by_zero", got.divide_by_zero, want.divide_by_zero);
                end
            end
            if (s_tvalid && s_tready)
                pending_quotients = {pending_quotients,
                    divide_truncating(s_tdata[WIDTH-1:0], s_tdata[2*WIDTH-1:WIDTH])};
        end
        outstanding <= pending_quotients.size();
    end

endmodule

// File: sim/signed_nonrestoring_divider_tb.sv
// Testbench top for the signed divider: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module signed_nonrestoring_divider_tb;
    import sdiv_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // dividend, divisor
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // quotient, remainder
    logic                m_tuser;   // divide_by_zero

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned items_sent = 0;
    bit          calm       = 1'b0;
    bit          held_off   = 1'b0;

    always #2 aclk = ~aclk;

    signed_nonrestoring_divider dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    quotient_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_operands(data_t num, data_t den);
        s_tdata  <= {den, num};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    function automatic data_t pick_operand(bit for_divisor);
        data_t extremes[5];
        extremes = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h0000};
        case ($urandom_range(0, 9))
            0:       return for_divisor ? data_t'(0) : extremes[$urandom_range(0, 4)];
            1:       return data_t'($urandom_range(0, 32) - 16);
            2:       return extremes[$urandom_range(0, 4)];
            default: return data_t'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        int dividends[24];
        int divisors[24];
        dividends = '{0, 1, -1, 32767, -32768, -32768, -32768, 32767,
                      0, -32768, 32767, 5, 7, -7, 7, -7,
                      6, -6, 32767, -32767, 1, -1, 100, -3};
        divisors  = '{1, 1, 1, 1, 1, -1, -32768, -32768,
                      0, 0, 0, 0, 2, 2, -2, -2,
                      3, 3, 32767, -32768, -32768, -1, -1, 7};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dividends[i])
            send_operands(data_t'(dividends[i]), data_t'(divisors[i]));
        for (int i = 0; i < 1950; i++) begin
            if (i >= 1650)
                calm = 1'b1;
            send_operands(pick_operand(1'b0), pick_operand(1'b1));
        end
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0)
            $display("[signed_nonrestoring_divider] OK");
        else
            $display("[signed_nonrestoring_divider] ERROR");
        $finish;
    end

    // result side back-pressure, with one long hold-off to fill the block
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (!held_off && items_sent >= 150) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        #2ms;
        $display("[signed_nonrestoring_divider] ERROR");
        $finish;
    end

endmodule
